FILE: rtl/rab_pkg.sv
// ----------------------------------------------------------------------------
// rab_pkg
// Shared constants and register indexes for the affine bounding-box block.
// ----------------------------------------------------------------------------
package rab_pkg;

    localparam int COORD_W        = 32;
    localparam int PROD_W         = 2 * COORD_W;
    localparam int CFG_IDX_W      = 3;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic signed [COORD_W-1:0] COEF_A_RST   = 32'sd65536;
    localparam logic signed [COORD_W-1:0] COEF_B_RST   = 32'sd0;
    localparam logic signed [COORD_W-1:0] COEF_C_RST   = 32'sd0;
    localparam logic signed [COORD_W-1:0] COEF_D_RST   = 32'sd65536;
    localparam logic signed [COORD_W-1:0] OFFSET_E_RST = 32'sd0;
    localparam logic signed [COORD_W-1:0] OFFSET_F_RST = 32'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_A       = 3'd0,
        REG_COEF_B       = 3'd1,
        REG_COEF_C       = 3'd2,
        REG_COEF_D       = 3'd3,
        REG_OFFSET_E     = 3'd4,
        REG_OFFSET_F     = 3'd5,
        REG_INTEGER_MODE = 3'd6
    } cfg_reg_t;

endpackage

FILE: rtl/rect_affine_bounds.sv
// ----------------------------------------------------------------------------
// rect_affine_bounds
// Bounding box of a rectangle mapped through a 2x3 fixed-point affine matrix.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_ready  | left_in top_in right_in bottom_in
//   out     | output    | out_valid/out_ready  | left_out top_out right_out
//           |           |                      | bottom_out clipped
//   cfg     | input     | cfg_we               | cfg_index cfg_data
//
// Four register stages: multiply, shift-add-saturate, truncate with pairwise
// min/max, final min/max into the output register. One transaction enters
// per cycle while in_ready is high. The stage ready chain starts at out_ready,
// so in a stall an occupied stage holds unless a later stage is empty, and empty stages fill.
// Reset clears the stage valid bits and loads the matrix with identity.
// ----------------------------------------------------------------------------
module rect_affine_bounds #(
    parameter int FRAC_BITS = rab_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [rab_pkg::COORD_W-1:0]  left_in,
    input  logic signed [rab_pkg::COORD_W-1:0]  top_in,
    input  logic signed [rab_pkg::COORD_W-1:0]  right_in,
    input  logic signed [rab_pkg::COORD_W-1:0]  bottom_in,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rab_pkg::COORD_W-1:0]  left_out,
    output logic signed [rab_pkg::COORD_W-1:0]  top_out,
    output logic signed [rab_pkg::COORD_W-1:0]  right_out,
    output logic signed [rab_pkg::COORD_W-1:0]  bottom_out,
    output logic                                clipped,

    input  logic                                cfg_we,
    input  logic [rab_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rab_pkg::COORD_W-1:0]         cfg_data
);

    localparam int CW    = rab_pkg::COORD_W;
    localparam int PW    = rab_pkg::PROD_W;
    localparam int SUM_W = PW + 2;

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        SUM_W'(signed'({1'b0, {(CW-1){1'b1}}}));
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        SUM_W'(signed'({1'b1, {(CW-1){1'b0}}}));
    localparam logic signed [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] FRAC_MASK = CW'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic [CW-1:0] FRAC_STEP = CW'(64'd1 << FRAC_BITS);

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [PW-1:0] prod_t;

    function automatic coord_t trunc_whole(input coord_t v);
        coord_t r;
        r = v & ~FRAC_MASK;
        if (v[CW-1] && ((v & FRAC_MASK) != '0))
        begin
            r = r + FRAC_STEP;
        end
        return r;
    endfunction

    function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] s);
        coord_t r;
        r = CW'(s);
        if (s > SAT_MAX)
        begin
            r = MAX_C;
        end
        else if (s < SAT_MIN)
        begin
            r = MIN_C;
        end
        return r;
    endfunction

    // configuration registers
    coord_t coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    coord_t offset_e_reg, offset_f_reg;
    logic   integer_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg       <= rab_pkg::COEF_A_RST;
            coef_b_reg       <= rab_pkg::COEF_B_RST;
            coef_c_reg       <= rab_pkg::COEF_C_RST;
            coef_d_reg       <= rab_pkg::COEF_D_RST;
            offset_e_reg     <= rab_pkg::OFFSET_E_RST;
            offset_f_reg     <= rab_pkg::OFFSET_F_RST;
            integer_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (rab_pkg::cfg_reg_t'(cfg_index))
                rab_pkg::REG_COEF_A:       coef_a_reg       <= coord_t'(cfg_data);
                rab_pkg::REG_COEF_B:       coef_b_reg       <= coord_t'(cfg_data);
                rab_pkg::REG_COEF_C:       coef_c_reg       <= coord_t'(cfg_data);
                rab_pkg::REG_COEF_D:       coef_d_reg       <= coord_t'(cfg_data);
                rab_pkg::REG_OFFSET_E:     offset_e_reg     <= coord_t'(cfg_data);
                rab_pkg::REG_OFFSET_F:     offset_f_reg     <= coord_t'(cfg_data);
                rab_pkg::REG_INTEGER_MODE: integer_mode_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // stage control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // stage 1: eight products, index 0 uses x0/y0, index 1 uses x1/y1
    prod_t  xa_reg [2], yc_reg [2], xb_reg [2], yd_reg [2];
    prod_t  xa_next [2], yc_next [2], xb_next [2], yd_next [2];
    coord_t raw1_reg [4];
    logic   inf1_reg;

    always_comb
    begin
        xa_next[0] = prod_t'(left_in)   * prod_t'(coef_a_reg);
        xa_next[1] = prod_t'(right_in)  * prod_t'(coef_a_reg);
        yc_next[0] = prod_t'(top_in)    * prod_t'(coef_c_reg);
        yc_next[1] = prod_t'(bottom_in) * prod_t'(coef_c_reg);
        xb_next[0] = prod_t'(left_in)   * prod_t'(coef_b_reg);
        xb_next[1] = prod_t'(right_in)  * prod_t'(coef_b_reg);
        yd_next[0] = prod_t'(top_in)    * prod_t'(coef_d_reg);
        yd_next[1] = prod_t'(bottom_in) * prod_t'(coef_d_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            xa_reg      <= xa_next;
            yc_reg      <= yc_next;
            xb_reg      <= xb_next;
            yd_reg      <= yd_next;
            raw1_reg[0] <= left_in;
            raw1_reg[1] <= top_in;
            raw1_reg[2] <= right_in;
            raw1_reg[3] <= bottom_in;
            inf1_reg    <= left_in > right_in;
        end
    end

    // stage 2: shift, add offset, saturate; corners (x0,y0)(x0,y1)(x1,y1)(x1,y0)
    localparam logic [3:0] CX_SEL = 4'b1100;
    localparam logic [3:0] CY_SEL = 4'b0110;

    coord_t tx2_reg [4], ty2_reg [4], raw2_reg [4];
    coord_t tx_next [4], ty_next [4];
    logic   clip2_reg, inf2_reg;
    logic   clip_next;
    logic signed [SUM_W-1:0] sx, sy;

    always_comb
    begin
        clip_next = 1'b0;
        sx        = '0;
        sy        = '0;
        for (int i = 0; i < 4; i++)
        begin
            sx = SUM_W'(xa_reg[CX_SEL[i]] >>> FRAC_BITS)
               + SUM_W'(yc_reg[CY_SEL[i]] >>> FRAC_BITS)
               + SUM_W'(offset_e_reg);
            sy = SUM_W'(xb_reg[CX_SEL[i]] >>> FRAC_BITS)
               + SUM_W'(yd_reg[CY_SEL[i]] >>> FRAC_BITS)
               + SUM_W'(offset_f_reg);
            tx_next[i] = sat_coord(sx);
            ty_next[i] = sat_coord(sy);
            if (sx > SAT_MAX || sx < SAT_MIN || sy > SAT_MAX || sy < SAT_MIN)
            begin
                clip_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            tx2_reg   <= tx_next;
            ty2_reg   <= ty_next;
            clip2_reg <= clip_next;
            raw2_reg  <= raw1_reg;
            inf2_reg  <= inf1_reg;
        end
    end

    // stage 3: truncate, pairwise min/max
    coord_t tx3 [4], ty3 [4];
    coord_t xmin3_reg [2], xmax3_reg [2], ymin3_reg [2], ymax3_reg [2];
    coord_t raw3_reg [4];
    logic   clip3_reg, inf3_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            tx3[i] = integer_mode_reg ? trunc_whole(tx2_reg[i]) : tx2_reg[i];
            ty3[i] = integer_mode_reg ? trunc_whole(ty2_reg[i]) : ty2_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            for (int p = 0; p < 2; p++)
            begin
                xmin3_reg[p] <= (tx3[2*p] < tx3[2*p+1]) ? tx3[2*p] : tx3[2*p+1];
                xmax3_reg[p] <= (tx3[2*p] > tx3[2*p+1]) ? tx3[2*p] : tx3[2*p+1];
                ymin3_reg[p] <= (ty3[2*p] < ty3[2*p+1]) ? ty3[2*p] : ty3[2*p+1];
                ymax3_reg[p] <= (ty3[2*p] > ty3[2*p+1]) ? ty3[2*p] : ty3[2*p+1];
            end
            clip3_reg <= clip2_reg;
            raw3_reg  <= raw2_reg;
            inf3_reg  <= inf2_reg;
        end
    end

    // stage 4: final min/max, pass infinite rectangles unchanged
    coord_t left_reg, top_reg, right_reg, bottom_reg;
    logic   clip4_reg;

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            if (inf3_reg)
            begin
                left_reg   <= raw3_reg[0];
                top_reg    <= raw3_reg[1];
                right_reg  <= raw3_reg[2];
                bottom_reg <= raw3_reg[3];
                clip4_reg  <= 1'b0;
            end
            else
            begin
                left_reg   <= (xmin3_reg[0] < xmin3_reg[1]) ? xmin3_reg[0] : xmin3_reg[1];
                right_reg  <= (xmax3_reg[0] > xmax3_reg[1]) ? xmax3_reg[0] : xmax3_reg[1];
                top_reg    <= (ymin3_reg[0] < ymin3_reg[1]) ? ymin3_reg[0] : ymin3_reg[1];
                bottom_reg <= (ymax3_reg[0] > ymax3_reg[1]) ? ymax3_reg[0] : ymax3_reg[1];
                clip4_reg  <= clip3_reg;
            end
        end
    end

    assign out_valid  = v4_reg;
    assign left_out   = left_reg;
    assign top_out    = top_reg;
    assign right_out  = right_reg;
    assign bottom_out = bottom_reg;
    assign clipped    = clip4_reg;

endmodule
